@@ rtl/core/kabp_pkg.sv @@
// Shared types and constants for the keyed alpha blend pixel unit.
// Holds the pixel item structs, the configuration struct and register map.
// No dependencies.
package kabp_pkg;

  // Configuration port geometry
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned ColorW   = 3 * ChanW;

  // Register indexes (byte address is 4 * index)
  typedef enum logic [1:0] {
    REG_KEYING_ENABLE = 2'd0,
    REG_MASK_COLOR    = 2'd1,
    REG_TEXT_COLOR    = 2'd2,
    REG_MIX_AMOUNT    = 2'd3
  } reg_idx_e;

  // Input item: foreground and background pixel
  typedef struct packed {
    logic [ChanW-1:0] fore_blue;
    logic [ChanW-1:0] fore_green;
    logic [ChanW-1:0] fore_red;
    logic [ChanW-1:0] back_blue;
    logic [ChanW-1:0] back_green;
    logic [ChanW-1:0] back_red;
  } pix_in_t;

  // Result item: blended pixel
  typedef struct packed {
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_red;
  } pix_out_t;

  // Live configuration handed from the register block to the datapath
  typedef struct packed {
    logic              keying_enable;
    logic [ColorW-1:0] mask_color;
    logic [ColorW-1:0] text_color;
    logic [ChanW-1:0]  mix_amount;
  } cfg_t;

  // Full-scale channel value, the background weight is this minus alpha
  localparam logic [ChanW-1:0] ChanMax = {ChanW{1'b1}};

  // Blend one channel: (back*(255-a) + fore*a) >> 8
  function automatic logic [ChanW-1:0] blend_chan(
    input logic [ChanW-1:0] back,
    input logic [ChanW-1:0] fore,
    input logic [ChanW-1:0] alpha
  );
    logic [2*ChanW-1:0] back_w;
    logic [2*ChanW-1:0] fore_w;
    logic [2*ChanW-1:0] sum;
    back_w = back * (ChanMax - alpha);
    fore_w = fore * alpha;
    sum    = back_w + fore_w;
    return sum[2*ChanW-1:ChanW];
  endfunction

endpackage

@@ rtl/core/keyed_alpha_blend_pixel_unit.sv @@
// Keyed alpha blend pixel unit: top level.
// Each accepted item is captured in the input register, then in the result register.
// Throughput: one item per cycle; the input stalls only while both stages hold
// items and the result side is stalled.
// Reset: asynchronous, active low; clears both stage valids and all config
// registers to zero. Depends on kabp_pkg, kabp_cfg_regs and kabp_pipe.
module keyed_alpha_blend_pixel_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kabp_pkg::CfgAddrW-1:0] paddr,
  input  logic [kabp_pkg::CfgDataW-1:0] pwdata,
  output logic [kabp_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  kabp_pkg::pix_in_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output kabp_pkg::pix_out_t            out_data_o
);
  import kabp_pkg::*;

  cfg_t cfg;

  // Configuration registers
  kabp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Item pipeline
  kabp_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/core/kabp_cfg_regs.sv @@
// APB-style configuration registers for the keyed alpha blend pixel unit.
// Depends on kabp_pkg for the register map and the configuration struct.
module kabp_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kabp_pkg::CfgAddrW-1:0]   paddr,
  input  logic [kabp_pkg::CfgDataW-1:0]   pwdata,
  output logic [kabp_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready,
  output kabp_pkg::cfg_t                  cfg_o
);
  import kabp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_KEYING_ENABLE: cfg_d.keying_enable = pwdata[0];
        REG_MASK_COLOR:    cfg_d.mask_color    = pwdata[ColorW-1:0];
        REG_TEXT_COLOR:    cfg_d.text_color    = pwdata[ColorW-1:0];
        REG_MIX_AMOUNT:    cfg_d.mix_amount    = pwdata[ChanW-1:0];
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_KEYING_ENABLE: prdata = {{(CfgDataW-1){1'b0}}, cfg_q.keying_enable};
      REG_MASK_COLOR:    prdata = {{(CfgDataW-ColorW){1'b0}}, cfg_q.mask_color};
      REG_TEXT_COLOR:    prdata = {{(CfgDataW-ColorW){1'b0}}, cfg_q.text_color};
      REG_MIX_AMOUNT:    prdata = {{(CfgDataW-ChanW){1'b0}}, cfg_q.mix_amount};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/kabp_mix.sv @@
// Combinational keying and blend of one pixel pair.
// Depends on kabp_pkg for item types, configuration struct and blend_chan.
module kabp_mix (
  input  kabp_pkg::cfg_t    cfg_i,
  input  kabp_pkg::pix_in_t pix_i,
  output kabp_pkg::pix_out_t pix_o,
  output logic              blended_o
);
  import kabp_pkg::*;

  logic [ColorW-1:0] fore_color;
  logic              mask_hit;
  logic              text_hit;
  pix_out_t          blend_pix;

  // Foreground packed in register layout: blue high, red low
  assign fore_color = {pix_i.fore_blue, pix_i.fore_green, pix_i.fore_red};
  assign mask_hit   = cfg_i.keying_enable && (fore_color == cfg_i.mask_color);
  assign text_hit   = cfg_i.keying_enable && (fore_color == cfg_i.text_color);

  // Per-channel weighted sum
  assign blend_pix.out_blue  = blend_chan(pix_i.back_blue,  pix_i.fore_blue,  cfg_i.mix_amount);
  assign blend_pix.out_green = blend_chan(pix_i.back_green, pix_i.fore_green, cfg_i.mix_amount);
  assign blend_pix.out_red   = blend_chan(pix_i.back_red,   pix_i.fore_red,   cfg_i.mix_amount);

  // Mask wins over text when both match
  always_comb begin
    blended_o = 1'b0;
    if (mask_hit) begin
      pix_o.out_blue  = pix_i.back_blue;
      pix_o.out_green = pix_i.back_green;
      pix_o.out_red   = pix_i.back_red;
    end else if (text_hit) begin
      pix_o.out_blue  = cfg_i.text_color[3*ChanW-1:2*ChanW];
      pix_o.out_green = cfg_i.text_color[2*ChanW-1:ChanW];
      pix_o.out_red   = cfg_i.text_color[ChanW-1:0];
    end else begin
      pix_o     = blend_pix;
      blended_o = 1'b1;
    end
  end

endmodule

@@ rtl/core/kabp_pipe.sv @@
// Two-stage item pipeline: input register, mix logic, result register.
// Depends on kabp_pkg and kabp_mix.
module kabp_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kabp_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kabp_pkg::pix_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kabp_pkg::pix_out_t out_data_o
);
  import kabp_pkg::*;

  logic     s1_valid_q, s1_valid_d;
  pix_in_t  s1_data_q;
  logic     s2_valid_q, s2_valid_d;
  pix_out_t s2_data_q;
  logic     s2_blended_q;
  logic     s1_stall;
  logic     s1_adv;
  logic     in_take;
  pix_out_t mix_pix;
  logic     mix_blended;

  // Stall propagation: a stage holds only while the one after it is full and held
  assign s1_stall   = s2_valid_q & out_stall_i;
  assign s1_adv     = s1_valid_q & ~s1_stall;
  assign in_stall_o = s1_valid_q & s1_stall;
  assign in_take    = in_valid_i & ~in_stall_o;

  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;
  assign s2_valid_d = s1_stall ? s2_valid_q : s1_valid_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
  end

  kabp_mix u_mix (
    .cfg_i     (cfg_i),
    .pix_i     (s1_data_q),
    .pix_o     (mix_pix),
    .blended_o (mix_blended)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_data_q    <= mix_pix;
      s2_blended_q <= mix_blended;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

`ifndef NO_ASSERTIONS
  // Input side only stalls when both stages are occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q))
    else $error("input stalled with a free stage");

  // An item leaving the input register lands in the result register
  a_adv_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> s2_valid_q)
    else $error("advanced item lost");

  // A blended channel never reaches full scale
  a_blend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_blended_q) |->
      (s2_data_q.out_blue != ChanMax && s2_data_q.out_green != ChanMax &&
       s2_data_q.out_red != ChanMax))
    else $error("blend result out of range");
`endif

endmodule
